/* sv/pqqs_pkg.sv */
// Shared types and constants for the priority queue quantum scheduler.
`default_nettype none
package pqqs_pkg;
	localparam int LEVELS = 4;
	localparam int TASK_SLOTS = 64;
	localparam int LW = $clog2(LEVELS);
	localparam int IW = $clog2(TASK_SLOTS);
	localparam int FW = $clog2(TASK_SLOTS + 1);
	localparam int QW = 16;

	localparam logic CMD_ARRIVE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [1:0] ST_ADMIT = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_RAN = 2'd2;
	localparam logic [1:0] ST_IDLE = 2'd3;

	localparam logic [0:0] REG_MODE = 1'b0;
	localparam logic [0:0] REG_CUTOFF = 1'b1;
	localparam logic [15:0] CUTOFF_RESET = 16'd99;

	typedef struct packed {
		logic cmd;
		logic [IW-1:0] id;
		logic [LW-1:0] lvl;
		logic [7:0] quanta;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [IW-1:0] rid;
		logic first;
		logic fin;
		logic [QW-1:0] qidx;
	} rsp_t;
endpackage
`default_nettype wire

/* sv/pqqs_front.sv */
// Input stage and request queue between the stream port and the scheduler core.
`default_nettype none
module pqqs_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire pqqs_pkg::req_t in_req,
	output logic q_valid,
	input wire logic q_pop,
	output pqqs_pkg::req_t q_req
);
	pqqs_pkg::req_t mem_q [2];
	logic [0:0] wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_req = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop && q_valid};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop of empty queue");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !in_ready) else $error("ready while full");
endmodule
`default_nettype wire

/* sv/pqqs_back.sv */
// Scheduler core: level FIFOs, per-task state, pick/run sequencer, output register.
`default_nettype none
module pqqs_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_pop,
	input wire pqqs_pkg::req_t q_req,
	input wire logic mode,
	input wire logic [15:0] cutoff,
	output logic out_valid,
	input wire logic out_ready,
	output pqqs_pkg::rsp_t out_rsp
);
	localparam int LW = pqqs_pkg::LW;
	localparam int IW = pqqs_pkg::IW;
	localparam int FW = pqqs_pkg::FW;
	localparam int DEPTH = pqqs_pkg::LEVELS * pqqs_pkg::TASK_SLOTS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PICK = 3'd1;
	localparam logic [2:0] S_HEAD = 3'd2;
	localparam logic [2:0] S_RUN = 3'd3;
	localparam logic [2:0] S_ROT = 3'd4;

	logic [2:0] state_q;
	logic [IW-1:0] fifo_q [DEPTH];
	logic [7:0] left_q [pqqs_pkg::TASK_SLOTS];
	logic [pqqs_pkg::TASK_SLOTS-1:0] ran_q;
	logic [IW-1:0] head_q [pqqs_pkg::LEVELS];
	logic [IW-1:0] tail_q [pqqs_pkg::LEVELS];
	logic [FW-1:0] fill_q [pqqs_pkg::LEVELS];
	logic [IW-1:0] cur_q;
	logic cur_v_q;
	logic [LW-1:0] cur_l_q;
	logic [15:0] qc_q;
	logic [IW-1:0] rd_q;
	logic [7:0] left_rd_q;
	pqqs_pkg::req_t req_q;
	logic ov_q;
	pqqs_pkg::rsp_t rsp_q;

	logic [LW-1:0] pick_l;
	logic pick_any;
	logic late;

	logic wr_en;
	logic [LW+IW-1:0] wr_addr;
	logic [IW-1:0] wr_data;
	logic lw_en;
	logic [IW-1:0] lw_addr;
	logic [7:0] lw_data;

	logic left_rd_q_ok;
	logic wait_q;

	always_comb begin
		pick_l = '0;
		pick_any = 1'b0;
		for (int i = pqqs_pkg::LEVELS - 1; i >= 0; i--) begin
			if (fill_q[i] != '0) begin
				pick_l = LW'(i);
				pick_any = 1'b1;
			end
		end
	end

	assign late = (qc_q > cutoff);
	assign q_pop = (state_q == S_IDLE) && q_valid && !ov_q;
	assign out_valid = ov_q;
	assign out_rsp = rsp_q;

	always_ff @(posedge clk) begin
		rd_q <= fifo_q[{pick_l, head_q[pick_l]}];
		if (wr_en) fifo_q[wr_addr] <= wr_data;
		if (lw_en) left_q[lw_addr] <= lw_data;
		left_rd_q <= left_q[cur_q];
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = {req_q.lvl, tail_q[req_q.lvl]};
		wr_data = req_q.id;
		lw_en = 1'b0;
		lw_addr = req_q.id;
		lw_data = req_q.quanta;
		if (state_q == S_PICK && req_q.cmd == pqqs_pkg::CMD_ARRIVE
				&& !late && fill_q[req_q.lvl] != FW'(pqqs_pkg::TASK_SLOTS)) begin
			wr_en = 1'b1;
			lw_en = 1'b1;
		end
		if (state_q == S_RUN && left_rd_q_ok) begin
			lw_en = 1'b1;
			lw_addr = cur_q;
			lw_data = (left_rd_q <= 8'd1) ? 8'd0 : left_rd_q - 8'd1;
		end
		if (state_q == S_ROT) begin
			wr_en = 1'b1;
			wr_addr = {cur_l_q, tail_q[cur_l_q]};
			wr_data = cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ran_q <= '0;
			cur_q <= '0;
			cur_v_q <= 1'b0;
			cur_l_q <= '0;
			qc_q <= '0;
			ov_q <= 1'b0;
			req_q <= '0;
			rsp_q <= '0;
			for (int i = 0; i < pqqs_pkg::LEVELS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						req_q <= q_req;
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					rsp_q.rid <= '0;
					rsp_q.first <= 1'b0;
					rsp_q.fin <= 1'b0;
					rsp_q.qidx <= qc_q;
					if (req_q.cmd == pqqs_pkg::CMD_ARRIVE) begin
						if (wr_en) begin
							tail_q[req_q.lvl] <= tail_q[req_q.lvl] + 1'b1;
							fill_q[req_q.lvl] <= fill_q[req_q.lvl] + 1'b1;
							ran_q[req_q.id] <= 1'b0;
							rsp_q.status <= pqqs_pkg::ST_ADMIT;
						end else begin
							rsp_q.status <= pqqs_pkg::ST_REJECT;
						end
						ov_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (cur_v_q && fill_q[cur_l_q] != '0) begin
						state_q <= S_RUN;
					end else if (!pick_any) begin
						cur_v_q <= 1'b0;
						rsp_q.status <= pqqs_pkg::ST_IDLE;
						if (qc_q != 16'hFFFF) qc_q <= qc_q + 16'd1;
						ov_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						cur_v_q <= 1'b0;
						cur_l_q <= pick_l;
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					// rd_q holds the head of level cur_l_q
					if (late && !ran_q[rd_q]) begin
						head_q[cur_l_q] <= head_q[cur_l_q] + 1'b1;
						fill_q[cur_l_q] <= fill_q[cur_l_q] - 1'b1;
						state_q <= S_PICK;
					end else begin
						cur_q <= rd_q;
						cur_v_q <= 1'b1;
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					// left_rd_q now holds quanta_left of cur_q
					if (left_rd_q_ok) begin
						rsp_q.status <= pqqs_pkg::ST_RAN;
						rsp_q.rid <= cur_q;
						rsp_q.first <= !ran_q[cur_q];
						ran_q[cur_q] <= 1'b1;
						rsp_q.fin <= (left_rd_q <= 8'd1);
						if (qc_q != 16'hFFFF) qc_q <= qc_q + 16'd1;
						if (left_rd_q <= 8'd1) begin
							head_q[cur_l_q] <= head_q[cur_l_q] + 1'b1;
							fill_q[cur_l_q] <= fill_q[cur_l_q] - 1'b1;
							cur_v_q <= 1'b0;
							ov_q <= 1'b1;
							state_q <= S_IDLE;
						end else if (mode) begin
							head_q[cur_l_q] <= head_q[cur_l_q] + 1'b1;
							cur_v_q <= 1'b0;
							state_q <= S_ROT;
						end else begin
							ov_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_ROT: begin
					tail_q[cur_l_q] <= tail_q[cur_l_q] + 1'b1;
					ov_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// left_rd_q is registered from cur_q; wait_q holds off the update until it reflects the settled cur_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wait_q <= 1'b0;
		else wait_q <= (state_q == S_RUN) && !wait_q;
	end
	assign left_rd_q_ok = wait_q;

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !ov_q) else $error("request taken while result pending");
	a_result_return: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROT) |=> (ov_q && state_q == S_IDLE)) else $error("rotate lost");
	a_cur_level_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HEAD) |-> (fill_q[cur_l_q] != '0)) else $error("head of empty level");
endmodule
`default_nettype wire

/* sv/priority_queue_quantum_scheduler.sv */
// Top level: stream ports, APB registers, front queue and scheduler core.
// Requests pass through the pick/read/update sequencer in the core, which handles
// one request at a time and waits for its result to leave: an arrival is admitted
// or rejected in S_PICK; a tick picks a level, reads its head, discards never-run
// tasks past the cutoff, runs one quantum of the current task and, in preempt mode,
// rotates it to the tail of its level. A two-entry queue in front accepts requests
// while the core works or a result waits.
`default_nettype none
module priority_queue_quantum_scheduler (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [15:0] s_tdata, // task_id[5:0], task_level[7:6], task_quanta[15:8]
	input wire logic s_tuser, // command
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [31:0] m_tdata, // status, running_id, first_run, finished, quantum_index
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	pqqs_pkg::req_t in_req, q_req;
	pqqs_pkg::rsp_t rsp;
	logic q_valid, q_pop;
	logic mode_q;
	logic [15:0] cutoff_q;

	assign in_req.cmd = s_tuser;
	assign in_req.id = s_tdata[5:0];
	assign in_req.lvl = s_tdata[7:6];
	assign in_req.quanta = s_tdata[15:8];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			cutoff_q <= pqqs_pkg::CUTOFF_RESET;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			if (paddr[2] == pqqs_pkg::REG_MODE) mode_q <= pwdata[0];
			else cutoff_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == pqqs_pkg::REG_CUTOFF) prdata = {16'd0, cutoff_q};
		else prdata = {31'd0, mode_q};
	end

	pqqs_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.in_req(in_req), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req)
	);

	pqqs_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop), .q_req(q_req),
		.mode(mode_q), .cutoff(cutoff_q), .out_valid(m_tvalid), .out_ready(m_tready),
		.out_rsp(rsp)
	);

	assign m_tdata = {6'd0, rsp.qidx, rsp.fin, rsp.first, rsp.rid, rsp.status};
endmodule
`default_nettype wire

/* bench/priority_queue_quantum_scheduler_test.sv */
// Stream and register testbench for the priority queue quantum scheduler.
`timescale 1ns / 100ps
`default_nettype none
module priority_queue_quantum_scheduler_test;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int LEVELS = pqqs_pkg::LEVELS;
	localparam int TASK_SLOTS = pqqs_pkg::TASK_SLOTS;
	localparam int IW = pqqs_pkg::IW;
	localparam int LW = pqqs_pkg::LW;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0; // task_id[5:0], task_level[7:6], task_quanta[15:8]
	logic s_tuser = 1'b0; // command
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata; // status[1:0], running_id[7:2], first_run[8], finished[9], quantum_index[25:10]
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	priority_queue_quantum_scheduler i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// scheduler shadow state
	logic [IW-1:0] lvl_fifo [LEVELS][TASK_SLOTS];
	int unsigned q_head [LEVELS];
	int unsigned q_tail [LEVELS];
	int unsigned q_fill [LEVELS];
	logic [7:0] left_quanta [TASK_SLOTS];
	bit started [TASK_SLOTS];
	logic [IW-1:0] cur_task;
	logic [LW-1:0] cur_lvl;
	bit cur_valid;
	logic [15:0] quantum_no;
	bit preempt;
	logic [15:0] cutoff;

	pqqs_pkg::req_t pending_reqs [$];
	pqqs_pkg::rsp_t expected_rsps [$];
	pqqs_pkg::req_t in_flight;
	int s_idle = 0;
	int r_idle = 0;
	int mismatches = 0;
	int results_seen = 0;
	int cycles = 0;

	function automatic logic [IW-1:0] fifo_take(int unsigned lv);
		logic [IW-1:0] id;
		id = lvl_fifo[lv][q_head[lv]];
		q_head[lv] = (q_head[lv] + 1) % TASK_SLOTS;
		q_fill[lv]--;
		return id;
	endfunction

	function automatic void fifo_put(int unsigned lv, logic [IW-1:0] id);
		lvl_fifo[lv][q_tail[lv]] = id;
		q_tail[lv] = (q_tail[lv] + 1) % TASK_SLOTS;
		q_fill[lv]++;
	endfunction

	function automatic bit pick_next();
		int unsigned lv;
		logic [IW-1:0] id;
		forever begin
			lv = 0;
			while (lv < LEVELS && q_fill[lv] == 0) lv++;
			if (lv == LEVELS) return 1'b0;
			id = lvl_fifo[lv][q_head[lv]];
			if (quantum_no > cutoff && !started[id]) begin
				// never-run task past the cutoff is dropped
				void'(fifo_take(lv));
				continue;
			end
			cur_task = id;
			cur_lvl = LW'(lv);
			cur_valid = 1'b1;
			return 1'b1;
		end
	endfunction

	task automatic schedule(input pqqs_pkg::req_t r);
		pqqs_pkg::rsp_t e;
		e = '0;
		e.qidx = quantum_no;
		if (r.cmd == pqqs_pkg::CMD_ARRIVE) begin
			if (quantum_no <= cutoff && q_fill[r.lvl] < TASK_SLOTS) begin
				fifo_put(r.lvl, r.id);
				left_quanta[r.id] = r.quanta;
				started[r.id] = 1'b0;
				e.status = pqqs_pkg::ST_ADMIT;
			end else
				e.status = pqqs_pkg::ST_REJECT;
		end else begin
			if (cur_valid && q_fill[cur_lvl] == 0) cur_valid = 1'b0;
			if (cur_valid || pick_next()) begin
				e.status = pqqs_pkg::ST_RAN;
				e.rid = cur_task;
				if (!started[cur_task]) begin
					e.first = 1'b1;
					started[cur_task] = 1'b1;
				end
				if (left_quanta[cur_task] <= 1) begin
					left_quanta[cur_task] = 0;
					e.fin = 1'b1;
					void'(fifo_take(cur_lvl));
					cur_valid = 1'b0;
				end else begin
					left_quanta[cur_task]--;
					if (preempt) begin
						fifo_put(cur_lvl, fifo_take(cur_lvl));
						cur_valid = 1'b0;
					end
				end
			end else
				e.status = pqqs_pkg::ST_IDLE;
			if (quantum_no != 16'hFFFF) quantum_no++;
		end
		expected_rsps.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) schedule(in_flight);
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= s_idle) begin
					in_flight = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {in_flight.quanta, in_flight.lvl, in_flight.id};
					s_tuser <= in_flight.cmd;
				end else
					s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		pqqs_pkg::rsp_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %h", m_tdata);
				end else begin
					e = expected_rsps.pop_front();
					if (m_tdata[1:0] !== e.status || m_tdata[7:2] !== e.rid
							|| m_tdata[8] !== e.first || m_tdata[9] !== e.fin
							|| m_tdata[25:10] !== e.qidx || m_tdata[31:26] !== 6'd0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected st=%0d id=%0d first=%0d fin=%0d q=%0d, got %h",
								e.status, e.rid, e.first, e.fin, e.qidx, m_tdata);
					end
				end
			end
			m_tready <= ($urandom_range(99) >= r_idle);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic add_req(input logic cmd, input int id, input int lv, input int qn);
		pqqs_pkg::req_t r;
		r.cmd = cmd;
		r.id = IW'(id);
		r.lvl = LW'(lv);
		r.quanta = 8'(qn);
		pending_reqs.push_back(r);
	endtask

	// sample at the falling edge so driver and monitor updates have settled
	task automatic drain();
		while (pending_reqs.size() != 0 || s_tvalid || expected_rsps.size() != 0)
			@(negedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic reg_write(input logic [0:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == pqqs_pkg::REG_MODE) preempt = val[0];
		else cutoff = val[15:0];
	endtask

	// mostly arrivals and ticks mixed, with occasional bursts that fill one level
	task automatic random_reqs(input int n);
		int k;
		int lv;
		k = 0;
		while (k < n) begin
			if ($urandom_range(99) < 3) begin
				lv = $urandom_range(LEVELS - 1);
				repeat (66) add_req(pqqs_pkg::CMD_ARRIVE, $urandom_range(63), lv,
					$urandom_range(1, 3));
				k += 66;
			end else if ($urandom_range(99) < 45) begin
				add_req(pqqs_pkg::CMD_ARRIVE, $urandom_range(63), $urandom_range(3),
					($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(0, 6));
				k++;
			end else begin
				add_req(pqqs_pkg::CMD_TICK, $urandom, $urandom, $urandom);
				k++;
			end
		end
	endtask

	initial begin
		for (int l = 0; l < LEVELS; l++) begin
			q_head[l] = 0;
			q_tail[l] = 0;
			q_fill[l] = 0;
		end
		for (int t = 0; t < TASK_SLOTS; t++) started[t] = 1'b0;
		cur_task = '0;
		cur_lvl = '0;
		cur_valid = 1'b0;
		quantum_no = '0;
		preempt = 1'b0;
		cutoff = pqqs_pkg::CUTOFF_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: extremes, zero quanta, duplicate id, idle tick
		s_idle = 7;
		r_idle = 73;
		add_req(pqqs_pkg::CMD_TICK, 0, 0, 0);
		add_req(pqqs_pkg::CMD_ARRIVE, 0, 0, 1);
		add_req(pqqs_pkg::CMD_ARRIVE, 63, 3, 255);
		add_req(pqqs_pkg::CMD_ARRIVE, 5, 1, 0);
		add_req(pqqs_pkg::CMD_ARRIVE, 5, 2, 2);
		add_req(pqqs_pkg::CMD_ARRIVE, 42, 1, 3);
		repeat (8) add_req(pqqs_pkg::CMD_TICK, 63, 3, 255);
		drain();
		reg_write(pqqs_pkg::REG_MODE, 32'd1);
		add_req(pqqs_pkg::CMD_ARRIVE, 7, 3, 2);
		repeat (6) add_req(pqqs_pkg::CMD_TICK, 0, 0, 0);
		drain();
		// cross the cutoff after running two fresh tasks; the last arrival lands past it
		reg_write(pqqs_pkg::REG_CUTOFF, quantum_no + 3);
		add_req(pqqs_pkg::CMD_ARRIVE, 9, 0, 2);
		add_req(pqqs_pkg::CMD_ARRIVE, 10, 1, 2);
		repeat (4) add_req(pqqs_pkg::CMD_TICK, 0, 0, 0);
		add_req(pqqs_pkg::CMD_ARRIVE, 11, 0, 1);
		drain();

		reg_write(pqqs_pkg::REG_CUTOFF, 32'hFFFF);
		reg_write(pqqs_pkg::REG_MODE, 32'd0);
		random_reqs(200);
		drain();
		reg_write(pqqs_pkg::REG_MODE, 32'd1);
		random_reqs(200);
		drain();
		s_idle = 73;
		r_idle = 7;
		reg_write(pqqs_pkg::REG_CUTOFF, quantum_no + 60);
		random_reqs(200);
		drain();
		reg_write(pqqs_pkg::REG_MODE, 32'd0);
		reg_write(pqqs_pkg::REG_CUTOFF, 32'd0);
		random_reqs(150);
		drain();
		s_idle = 0;
		r_idle = 0;
		reg_write(pqqs_pkg::REG_CUTOFF, quantum_no + 80);
		random_reqs(250);
		drain();
		reg_write(pqqs_pkg::REG_MODE, 32'd1);
		reg_write(pqqs_pkg::REG_CUTOFF, 32'hFFFF);
		random_reqs(200);
		drain();

		$display("%0d results checked across both modes, cutoff crossings and full levels",
			results_seen);
		$display("%0d mismatches, final quantum %0d", mismatches, quantum_no);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire
